// ===== sv/cfifo_pkg.sv =====
// Shared constants and types for the circular FIFO with search.
// Holds storage geometry, field widths and operation codes; depends on nothing.
`default_nettype none

package cfifo_pkg;

    // Storage geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field types.
    typedef logic [2:0]            kind_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Operation codes carried in the kind field.
    localparam kind_t OP_ENQ   = 3'd0;
    localparam kind_t OP_DEQ   = 3'd1;
    localparam kind_t OP_PEEK  = 3'd2;
    localparam kind_t OP_CLEAR = 3'd3;
    localparam kind_t OP_FIND  = 3'd4;
    localparam kind_t OP_COUNT = 3'd5;

endpackage

`default_nettype wire

// ===== sv/circular_fifo_with_search.sv =====
// Ring-buffer FIFO with configurable capacity, find and count operations.
// Depends on cfifo_pkg for geometry, field types and operation codes.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+----------------------------------------------
//   input    | in_valid / in_ready      | kind, value
//   output   | out_valid / out_ready    | data, data_valid, accepted, match_found,
//            |                          | match_slot, match_count, occupancy,
//            |                          | empty, is_full
//   config   | cfg_write (no wait)      | cfg_data (capacity)
//
// Enqueue, clear, unknown kinds and empty-ring reads go straight to the result; other
// reads make one registered read of the slot memory; find and count scan the stored
// entries: the scan issues one memory read per stored entry and compares it
// the cycle after. Find stops at its first match. A finished result sits in
// the output register, so the next transfer is taken while it waits; a stalled
// output only holds the block at the end of the following operation.
// Reset clears the pointers, the fill count and the capacity (to DEPTH).
`default_nettype none

module circular_fifo_with_search
(
    input  wire                        clk,
    input  wire                        rst_n,
    // Input channel.
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [2:0]                 kind,
    input  wire  [7:0]                 value,
    // Output channel.
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [7:0]                 data,
    output logic                       data_valid,
    output logic                       accepted,
    output logic                       match_found,
    output logic [3:0]                 match_slot,
    output logic [4:0]                 match_count,
    output logic [4:0]                 occupancy,
    output logic                       empty,
    output logic                       is_full,
    // Capacity register write.
    input  wire                        cfg_write,
    input  wire  [4:0]                 cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SCAN, ST_EMIT} state_t;

    // Slot memory, one write and one registered read port.
    cfifo_pkg::data_t mem [cfifo_pkg::DEPTH];
    logic             mem_we;
    cfifo_pkg::idx_t  mem_waddr;
    cfifo_pkg::data_t mem_wdata;
    cfifo_pkg::idx_t  rd_addr;
    cfifo_pkg::data_t rd_data_reg;

    // Control and result registers.
    state_t           state_reg, state_next;
    logic [4:0]       cap_reg, cap_next;
    cfifo_pkg::idx_t  head_reg, head_next;
    cfifo_pkg::idx_t  tail_reg, tail_next;
    cfifo_pkg::cnt_t  fill_reg, fill_next;
    cfifo_pkg::kind_t kind_reg, kind_next;
    cfifo_pkg::data_t key_reg, key_next;
    cfifo_pkg::idx_t  ptr_reg, ptr_next;
    cfifo_pkg::cnt_t  left_reg, left_next;
    logic             pend_reg, pend_next;
    cfifo_pkg::idx_t  pend_slot_reg, pend_slot_next;
    cfifo_pkg::data_t res_data_reg, res_data_next;
    logic             res_dv_reg, res_dv_next;
    logic             res_acc_reg, res_acc_next;
    logic             res_found_reg, res_found_next;
    cfifo_pkg::idx_t  res_slot_reg, res_slot_next;
    cfifo_pkg::cnt_t  res_cnt_reg, res_cnt_next;

    // Output registers.
    logic             out_valid_reg, out_valid_next;
    cfifo_pkg::data_t data_reg, data_next;
    logic             data_valid_reg, data_valid_next;
    logic             accepted_reg, accepted_next;
    logic             match_found_reg, match_found_next;
    cfifo_pkg::idx_t  match_slot_reg, match_slot_next;
    cfifo_pkg::cnt_t  match_count_reg, match_count_next;
    cfifo_pkg::cnt_t  occupancy_reg, occupancy_next;
    logic             empty_reg, empty_next;
    logic             is_full_reg, is_full_next;

    cfifo_pkg::cnt_t  cap_eff;
    logic             hit;
    logic             stop_issue;

    // Advance a ring index, wrapping at the effective capacity.
    function automatic cfifo_pkg::idx_t ring_next(input cfifo_pkg::idx_t idx,
                                                  input cfifo_pkg::cnt_t cap);
        cfifo_pkg::idx_t result;
        if ({1'b0, idx} == cap - cfifo_pkg::cnt_t'(1))
        begin
            result = '0;
        end
        else
        begin
            result = idx + cfifo_pkg::idx_t'(1);
        end
        return result;
    endfunction

    // A capacity of zero acts as one, anything above the depth as the depth.
    always_comb
    begin
        if (cap_reg == 5'd0)
        begin
            cap_eff = cfifo_pkg::cnt_t'(1);
        end
        else if ({1'b0, cap_reg} > 6'(cfifo_pkg::DEPTH))
        begin
            cap_eff = cfifo_pkg::cnt_t'(cfifo_pkg::DEPTH);
        end
        else
        begin
            cap_eff = cfifo_pkg::cnt_t'(cap_reg);
        end
    end

    // Scan compare: the data read last cycle against the key.
    assign hit = pend_reg && (rd_data_reg == key_reg)
                 && !((kind_reg == cfifo_pkg::OP_FIND) && res_found_reg);
    assign stop_issue = (kind_reg == cfifo_pkg::OP_FIND) && (res_found_reg || hit);

    // Sequencer: operation decode, memory accesses and result assembly.
    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        ptr_next         = ptr_reg;
        left_next        = left_reg;
        pend_next        = pend_reg;
        pend_slot_next   = pend_slot_reg;
        res_data_next    = res_data_reg;
        res_dv_next      = res_dv_reg;
        res_acc_next     = res_acc_reg;
        res_found_next   = res_found_reg;
        res_slot_next    = res_slot_reg;
        res_cnt_next     = res_cnt_reg;
        out_valid_next   = out_valid_reg;
        data_next        = data_reg;
        data_valid_next  = data_valid_reg;
        accepted_next    = accepted_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        match_count_next = match_count_reg;
        occupancy_next   = occupancy_reg;
        empty_next       = empty_reg;
        is_full_next     = is_full_reg;
        mem_we           = 1'b0;
        mem_waddr        = tail_reg;
        mem_wdata        = key_reg;
        rd_addr          = head_reg;
        in_ready         = 1'b0;

        // The output register empties on a transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next      = kind;
                    key_next       = value;
                    res_data_next  = '0;
                    res_dv_next    = 1'b0;
                    res_acc_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                    res_cnt_next   = '0;
                    state_next     = ST_EMIT;
                    case (kind)
                        cfifo_pkg::OP_ENQ:
                        begin
                            if (fill_reg < cap_eff)
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = tail_reg;
                                mem_wdata    = value;
                                tail_next    = ring_next(tail_reg, cap_eff);
                                fill_next    = fill_reg + cfifo_pkg::cnt_t'(1);
                                res_acc_next = 1'b1;
                            end
                        end
                        cfifo_pkg::OP_DEQ, cfifo_pkg::OP_PEEK:
                        begin
                            if (fill_reg != '0)
                            begin
                                rd_addr    = head_reg;
                                state_next = ST_READ;
                            end
                        end
                        cfifo_pkg::OP_CLEAR:
                        begin
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                        end
                        cfifo_pkg::OP_FIND, cfifo_pkg::OP_COUNT:
                        begin
                            ptr_next   = head_reg;
                            left_next  = fill_reg;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                res_data_next = rd_data_reg;
                res_dv_next   = 1'b1;
                if (kind_reg == cfifo_pkg::OP_DEQ)
                begin
                    head_next = ring_next(head_reg, cap_eff);
                    fill_next = fill_reg - cfifo_pkg::cnt_t'(1);
                end
                state_next = ST_EMIT;
            end

            ST_SCAN:
            begin
                rd_addr = ptr_reg;
                // Compare the entry read last cycle.
                if (hit)
                begin
                    if (kind_reg == cfifo_pkg::OP_FIND)
                    begin
                        res_found_next = 1'b1;
                        res_slot_next  = pend_slot_reg;
                    end
                    else
                    begin
                        res_cnt_next = res_cnt_reg + cfifo_pkg::cnt_t'(1);
                    end
                end
                // Issue the next read, or finish once nothing is in flight.
                if ((left_reg != '0) && !stop_issue)
                begin
                    pend_next      = 1'b1;
                    pend_slot_next = ptr_reg;
                    ptr_next       = ring_next(ptr_reg, cap_eff);
                    left_next      = left_reg - cfifo_pkg::cnt_t'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    data_next        = res_data_reg;
                    data_valid_next  = res_dv_reg;
                    accepted_next    = res_acc_reg;
                    match_found_next = res_found_reg;
                    match_slot_next  = res_slot_reg;
                    match_count_next = res_cnt_reg;
                    occupancy_next   = fill_reg;
                    empty_next       = (fill_reg == '0);
                    is_full_next     = (fill_reg == cap_eff);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Capacity write empties the ring; user writes only while idle, unchecked.
        if (cfg_write)
        begin
            cap_next  = cfg_data;
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cap_reg         <= 5'(cfifo_pkg::DEPTH);
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            kind_reg        <= '0;
            key_reg         <= '0;
            ptr_reg         <= '0;
            left_reg        <= '0;
            pend_reg        <= 1'b0;
            pend_slot_reg   <= '0;
            res_data_reg    <= '0;
            res_dv_reg      <= 1'b0;
            res_acc_reg     <= 1'b0;
            res_found_reg   <= 1'b0;
            res_slot_reg    <= '0;
            res_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            data_reg        <= '0;
            data_valid_reg  <= 1'b0;
            accepted_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            match_slot_reg  <= '0;
            match_count_reg <= '0;
            occupancy_reg   <= '0;
            empty_reg       <= 1'b1;
            is_full_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cap_reg         <= cap_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fill_reg        <= fill_next;
            kind_reg        <= kind_next;
            key_reg         <= key_next;
            ptr_reg         <= ptr_next;
            left_reg        <= left_next;
            pend_reg        <= pend_next;
            pend_slot_reg   <= pend_slot_next;
            res_data_reg    <= res_data_next;
            res_dv_reg      <= res_dv_next;
            res_acc_reg     <= res_acc_next;
            res_found_reg   <= res_found_next;
            res_slot_reg    <= res_slot_next;
            res_cnt_reg     <= res_cnt_next;
            out_valid_reg   <= out_valid_next;
            data_reg        <= data_next;
            data_valid_reg  <= data_valid_next;
            accepted_reg    <= accepted_next;
            match_found_reg <= match_found_next;
            match_slot_reg  <= match_slot_next;
            match_count_reg <= match_count_next;
            occupancy_reg   <= occupancy_next;
            empty_reg       <= empty_next;
            is_full_reg     <= is_full_next;
        end
    end

    // Slot memory: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Port drivers.
    assign out_valid   = out_valid_reg;
    assign data        = data_reg;
    assign data_valid  = data_valid_reg;
    assign accepted    = accepted_reg;
    assign match_found = match_found_reg;
    assign match_slot  = match_slot_reg;
    assign match_count = match_count_reg;
    assign occupancy   = occupancy_reg;
    assign empty       = empty_reg;
    assign is_full     = is_full_reg;

endmodule

`default_nettype wire

// ===== verif/tb_circular_fifo_with_search.sv =====
// Self-checking testbench for the circular FIFO with search.
// Depends on cfifo_pkg and circular_fifo_with_search; predicts every result
// from its own model of the ring and compares each output transfer to it.
module tb_circular_fifo_with_search;

    timeunit 1ns;
    timeprecision 1ps;

    // Kinds outside the operation set; the block must treat them as no-ops.
    localparam cfifo_pkg::kind_t OP_RSVD_A = 3'd6;
    localparam cfifo_pkg::kind_t OP_RSVD_B = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_SEGMENTS  = 8;
    localparam int SEG_ITEMS     = 100;
    localparam int PRESSURE_SEG  = 6;

    typedef struct packed {
        cfifo_pkg::kind_t op;
        cfifo_pkg::data_t operand;
    } fifo_op_t;

    typedef struct packed {
        cfifo_pkg::data_t data;
        logic             data_valid;
        logic             accepted;
        logic             match_found;
        cfifo_pkg::idx_t  match_slot;
        cfifo_pkg::cnt_t  match_count;
        cfifo_pkg::cnt_t  occupancy;
        logic             empty;
        logic             is_full;
    } fifo_result_t;

    // Block ports.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] kind = '0;
    logic [7:0] value = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data;
    logic       data_valid;
    logic       accepted;
    logic       match_found;
    logic [3:0] match_slot;
    logic [4:0] match_count;
    logic [4:0] occupancy;
    logic       empty;
    logic       is_full;
    logic       cfg_write = 1'b0;
    logic [4:0] cfg_data = 5'd16;

    // Stimulus and scoreboard state.
    fifo_op_t     ops_waiting[$];
    fifo_result_t results_due[$];
    logic         in_taken = 1'b0;
    logic         hold_off = 1'b0;
    logic         pressure_go = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           ops_sent = 0;
    int           results_seen = 0;
    int           cap_writes = 0;

    // Model of the ring.
    cfifo_pkg::data_t ring_mem [cfifo_pkg::DEPTH];
    logic [4:0]       cap_setting = 5'd16;
    int               head_pos = 0;
    int               tail_pos = 0;
    int               fill = 0;
    int               full_rejects = 0;
    int               empty_reads = 0;
    int               find_hits = 0;

    circular_fifo_with_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data        (data),
        .data_valid  (data_valid),
        .accepted    (accepted),
        .match_found (match_found),
        .match_slot  (match_slot),
        .match_count (match_count),
        .occupancy   (occupancy),
        .empty       (empty),
        .is_full     (is_full),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The register value in use: zero acts as one, anything above the depth as the depth.
    function automatic int ring_size();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > cfifo_pkg::DEPTH)
            return cfifo_pkg::DEPTH;
        return int'(cap_setting);
    endfunction

    // Apply one operation to the model and return the result it must produce.
    function automatic fifo_result_t predict_op(cfifo_pkg::kind_t op,
                                                cfifo_pkg::data_t operand);
        fifo_result_t r;
        int           cap;
        int           pos;
        r = '0;
        cap = ring_size();
        case (op)
            cfifo_pkg::OP_ENQ:
            begin
                if (fill < cap)
                begin
                    ring_mem[tail_pos] = operand;
                    tail_pos = (tail_pos + 1) % cap;
                    fill++;
                    r.accepted = 1'b1;
                end
                else
                    full_rejects++;
            end
            cfifo_pkg::OP_DEQ, cfifo_pkg::OP_PEEK:
            begin
                if (fill > 0)
                begin
                    r.data = ring_mem[head_pos];
                    r.data_valid = 1'b1;
                    if (op == cfifo_pkg::OP_DEQ)
                    begin
                        head_pos = (head_pos + 1) % cap;
                        fill--;
                    end
                end
                else
                    empty_reads++;
            end
            cfifo_pkg::OP_CLEAR:
            begin
                head_pos = 0;
                tail_pos = 0;
                fill = 0;
            end
            cfifo_pkg::OP_FIND:
            begin
                // Oldest match wins; the slot reported is the physical one.
                for (int i = 0; i < fill; i++)
                begin
                    pos = (head_pos + i) % cap;
                    if (!r.match_found && ring_mem[pos] == operand)
                    begin
                        r.match_found = 1'b1;
                        r.match_slot = cfifo_pkg::idx_t'(pos);
                    end
                end
                if (r.match_found)
                    find_hits++;
            end
            cfifo_pkg::OP_COUNT:
            begin
                for (int i = 0; i < fill; i++)
                begin
                    pos = (head_pos + i) % cap;
                    if (ring_mem[pos] == operand)
                        r.match_count = r.match_count + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = cfifo_pkg::cnt_t'(fill);
        r.empty = (fill == 0);
        r.is_full = (fill == cap);
        return r;
    endfunction

    // Print one line per failure and count every one.
    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Input driver: hold the payload until the transfer, then maybe idle.
    always @(negedge clk)
    begin : drive_ops
        fifo_op_t next_op;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (ops_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_op = ops_waiting.pop_front();
                in_valid <= 1'b1;
                kind <= next_op.op;
                value <= next_op.operand;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: random stalls, plus the long hold-off when it is active.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps offering items.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Monitor: track register writes and input transfers, check output transfers.
    always @(posedge clk)
    begin : watch_ports
        fifo_result_t got;
        fifo_result_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                cap_setting = cfg_data;
                head_pos = 0;
                tail_pos = 0;
                fill = 0;
            end
            if (in_valid && in_ready)
            begin
                in_taken = 1'b1;
                ops_sent++;
                results_due.push_back(predict_op(kind, value));
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                else
                begin
                    want = results_due.pop_front();
                    got.data = data;
                    got.data_valid = data_valid;
                    got.accepted = accepted;
                    got.match_found = match_found;
                    got.match_slot = match_slot;
                    got.match_count = match_count;
                    got.occupancy = occupancy;
                    got.empty = empty;
                    got.is_full = is_full;
                    check_field("data", got.data, want.data);
                    check_field("data_valid", got.data_valid, want.data_valid);
                    check_field("accepted", got.accepted, want.accepted);
                    check_field("match_found", got.match_found, want.match_found);
                    check_field("match_slot", got.match_slot, want.match_slot);
                    check_field("match_count", got.match_count, want.match_count);
                    check_field("occupancy", got.occupancy, want.occupancy);
                    check_field("empty", got.empty, want.empty);
                    check_field("is_full", got.is_full, want.is_full);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_circular_fifo_with_search: errors");
        $finish;
    end

    task automatic queue_op(cfifo_pkg::kind_t op, cfifo_pkg::data_t operand);
        fifo_op_t item;
        item.op = op;
        item.operand = operand;
        ops_waiting.push_back(item);
    endtask

    // Wait until every item is sent and every result is back, then let it settle.
    task automatic wait_idle();
        while (ops_waiting.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] setting);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= setting;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        cap_writes++;
    endtask

    // Enqueue-heavy traffic, with searches, reads, rare clears and reserved kinds.
    function automatic cfifo_pkg::kind_t pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return cfifo_pkg::OP_ENQ;
        if (r < 55)
            return cfifo_pkg::OP_DEQ;
        if (r < 65)
            return cfifo_pkg::OP_PEEK;
        if (r < 80)
            return cfifo_pkg::OP_FIND;
        if (r < 92)
            return cfifo_pkg::OP_COUNT;
        if (r < 95)
            return cfifo_pkg::OP_CLEAR;
        return ($urandom_range(1) != 0) ? OP_RSVD_A : OP_RSVD_B;
    endfunction

    // Half the values come from a small pool so searches find repeated keys.
    function automatic cfifo_pkg::data_t pick_operand();
        cfifo_pkg::data_t key_pool [4];
        key_pool[0] = 8'h00;
        key_pool[1] = 8'hFF;
        key_pool[2] = 8'h5A;
        key_pool[3] = 8'hA5;
        if ($urandom_range(99) < 50)
            return key_pool[2'($urandom_range(3))];
        return cfifo_pkg::data_t'($urandom_range(255));
    endfunction

    // Stimulus sequence.
    initial
    begin : stimulus
        logic [4:0] cap_plan [NUM_SEGMENTS];
        for (int i = 0; i < cfifo_pkg::DEPTH; i++)
            ring_mem[i] = '0;
        cap_plan[0] = 5'd16;
        cap_plan[1] = 5'd0;
        cap_plan[2] = 5'd3;
        cap_plan[3] = 5'd31;
        cap_plan[4] = 5'd1;
        cap_plan[5] = 5'd17;
        cap_plan[6] = 5'd16;
        cap_plan[7] = 5'($urandom_range(2, 15));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue reads, searches, duplicates, reserved kinds, clear.
        send_idle_pct = 25;
        recv_stall_pct = 87;
        queue_op(cfifo_pkg::OP_PEEK, 8'h00);
        queue_op(cfifo_pkg::OP_DEQ, 8'h00);
        queue_op(cfifo_pkg::OP_FIND, 8'h00);
        queue_op(cfifo_pkg::OP_COUNT, 8'h00);
        queue_op(cfifo_pkg::OP_ENQ, 8'h00);
        queue_op(cfifo_pkg::OP_ENQ, 8'hFF);
        queue_op(cfifo_pkg::OP_ENQ, 8'hA5);
        queue_op(cfifo_pkg::OP_ENQ, 8'hFF);
        queue_op(cfifo_pkg::OP_FIND, 8'hFF);
        queue_op(cfifo_pkg::OP_FIND, 8'h77);
        queue_op(cfifo_pkg::OP_COUNT, 8'hFF);
        queue_op(cfifo_pkg::OP_PEEK, 8'h00);
        queue_op(cfifo_pkg::OP_DEQ, 8'h00);
        queue_op(OP_RSVD_A, 8'hFF);
        queue_op(OP_RSVD_B, 8'h00);
        queue_op(cfifo_pkg::OP_CLEAR, 8'h00);
        queue_op(cfifo_pkg::OP_DEQ, 8'h00);
        wait_idle();

        // Directed: a ring of one slot, enqueue when full.
        write_capacity(5'd1);
        queue_op(cfifo_pkg::OP_ENQ, 8'h3C);
        queue_op(cfifo_pkg::OP_ENQ, 8'hC3);
        queue_op(cfifo_pkg::OP_FIND, 8'h3C);
        queue_op(cfifo_pkg::OP_DEQ, 8'h00);

        // Random segments, each with a capacity from the plan and one of three idle patterns.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            wait_idle();
            if (seg < 3)
            begin
                send_idle_pct = 25;
                recv_stall_pct = 87;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 87;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_capacity(cap_plan[seg]);
            if (seg == PRESSURE_SEG)
                pressure_go = 1'b1;
            repeat (SEG_ITEMS)
                queue_op(pick_op(), pick_operand());
        end
        wait_idle();

        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        $display("Run covered %0d operations and %0d results over %0d capacity writes.",
                 ops_sent, results_seen, cap_writes);
        $display("Full rejections %0d, empty reads %0d, find hits %0d, mismatches %0d.",
                 full_rejects, empty_reads, find_hits, mismatches);
        if (mismatches == 0)
            $display("tb_circular_fifo_with_search: clean");
        else
            $display("tb_circular_fifo_with_search: errors");
        $finish;
    end

endmodule

// ===== circular_fifo_with_search.f =====
sv/cfifo_pkg.sv
sv/circular_fifo_with_search.sv
verif/tb_circular_fifo_with_search.sv
